// ===== design/m3i_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants of the 3x3 fixed-point matrix inverter.
// -----------------------------------------------------------------------------
package m3i_pkg;

   // element format: signed Q16.16
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_W     = 31;

   // full-width intermediates
   localparam int PROD_W = 2 * ELEM_W;          // 2x2 minor product
   localparam int COF_W  = PROD_W + 1;          // cofactor
   localparam int LO_W   = ELEM_W + 1;          // low slice of a cofactor
   localparam int HI_W   = COF_W - LO_W;        // high slice of a cofactor
   localparam int PART_W = ELEM_W + LO_W + 1;   // partial determinant product
   localparam int DET_W  = ELEM_W + COF_W + 2;  // determinant
   localparam int MAG_W  = DET_W - 1;           // divider magnitudes
   localparam int CMAG_W = PROD_W;              // cofactor magnitude
   localparam int QUO_W  = ELEM_W;              // quotient bits formed

   // pipeline depths
   localparam int COF_LAT   = 2;
   localparam int DET_LAT   = 5;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int LATENCY   = COF_LAT + DET_LAT + DIV_LAT + 1;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [PART_W-1:0] part_type;
   typedef logic signed [DET_W-1:0]  det_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [CMAG_W-1:0]        cmag_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [THR_W-1:0]         thr_type;

   // 1.0 in the element format
   localparam elem_type ELEM_ONE = elem_type'(1) << FRAC_BITS;

   // minor element indexes for each cofactor: c = a[i0]*a[i1] - a[i2]*a[i3]
   localparam logic [3:0] COF_IDX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // control traveling beside the divider lanes
   typedef struct packed {
      logic valid;
      logic singular;
   } ctl_type;

endpackage
`default_nettype wire

// ===== design/m3i_cofactor.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// m3i_cofactor
// Two-stage cofactor unit: registered minor products, then cofactor differences.
// -----------------------------------------------------------------------------
module m3i_cofactor (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  m3i_pkg::elem_type   elem [9],
   output logic                out_valid,
   output m3i_pkg::elem_type   row0 [3],
   output m3i_pkg::cof_type    cof [9]
);

   m3i_pkg::prod_type prod_p_in [9];
   m3i_pkg::prod_type prod_q_in [9];
   m3i_pkg::prod_type prod_p_ff [9];
   m3i_pkg::prod_type prod_q_ff [9];
   m3i_pkg::elem_type row0_s1_ff [3];
   m3i_pkg::elem_type row0_s2_ff [3];
   m3i_pkg::cof_type  cof_in [9];
   m3i_pkg::cof_type  cof_ff [9];
   logic              valid_s1_ff;
   logic              valid_s2_ff;

   // minor products, full width
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         prod_p_in[i] = m3i_pkg::prod_type'(elem[m3i_pkg::COF_IDX[i][0]])
                      * m3i_pkg::prod_type'(elem[m3i_pkg::COF_IDX[i][1]]);
         prod_q_in[i] = m3i_pkg::prod_type'(elem[m3i_pkg::COF_IDX[i][2]])
                      * m3i_pkg::prod_type'(elem[m3i_pkg::COF_IDX[i][3]]);
      end
   end

   // cofactor differences
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         cof_in[i] = m3i_pkg::cof_type'(prod_p_ff[i]) - m3i_pkg::cof_type'(prod_q_ff[i]);
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      prod_p_ff  <= prod_p_in;
      prod_q_ff  <= prod_q_in;
      row0_s1_ff <= elem[0:2];
      row0_s2_ff <= row0_s1_ff;
      cof_ff     <= cof_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s1_ff <= in_valid;
         valid_s2_ff <= valid_s1_ff;
      end
   end

   assign out_valid = valid_s2_ff;
   assign row0      = row0_s2_ff;
   assign cof       = cof_ff;

endmodule
`default_nettype wire

// ===== design/m3i_det.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// m3i_det
// Determinant by first-row expansion, singular test and divider operand setup.
// -----------------------------------------------------------------------------
module m3i_det (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  m3i_pkg::elem_type   row0 [3],
   input  m3i_pkg::cof_type    cof [9],
   input  m3i_pkg::thr_type    threshold,
   output m3i_pkg::ctl_type    out_ctl,
   output m3i_pkg::mag_type    den,
   output m3i_pkg::mag_type    num [9],
   output logic                neg [9],
   output logic                big [9]
);

   localparam int SHIFT2 = 2 * m3i_pkg::FRAC_BITS;

   m3i_pkg::part_type lo_in [3];
   m3i_pkg::part_type hi_in [3];
   m3i_pkg::part_type lo_ff [3];
   m3i_pkg::part_type hi_ff [3];
   m3i_pkg::det_type  term_in [3];
   m3i_pkg::det_type  term_ff [3];
   m3i_pkg::det_type  det_in;
   m3i_pkg::det_type  det_ff;
   m3i_pkg::cof_type  cof_s3_ff [9];
   m3i_pkg::cof_type  cof_s4_ff [9];
   m3i_pkg::cof_type  cof_s5_ff [9];
   m3i_pkg::mag_type  dm_in;
   m3i_pkg::mag_type  dm_ff;
   m3i_pkg::mag_type  thr_big;
   logic              sing_in;
   logic              sing_s6_ff;
   logic              sing_s7_ff;
   m3i_pkg::cmag_type cm_in [9];
   m3i_pkg::cmag_type cm_ff [9];
   logic              neg_in [9];
   logic              neg_s6_ff [9];
   logic              neg_s7_ff [9];
   m3i_pkg::mag_type  num_in [9];
   m3i_pkg::mag_type  num_ff [9];
   m3i_pkg::mag_type  den_in;
   m3i_pkg::mag_type  den_ff;
   logic              big_in [9];
   logic              big_ff [9];
   logic [4:0]        valid_ff;

   // split products: row element times low and high slices of its cofactor
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = m3i_pkg::part_type'(row0[k])
                  * m3i_pkg::part_type'($signed({1'b0, cof[3*k][m3i_pkg::LO_W-1:0]}));
         hi_in[k] = m3i_pkg::part_type'(row0[k])
                  * m3i_pkg::part_type'($signed(cof[3*k][m3i_pkg::COF_W-1:m3i_pkg::LO_W]));
      end
   end

   // recombine slices, then sum the three terms
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = (m3i_pkg::det_type'(hi_ff[k]) <<< m3i_pkg::LO_W)
                    + m3i_pkg::det_type'(lo_ff[k]);
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   // magnitudes, signs and singular test
   always_comb begin
      dm_in   = m3i_pkg::MAG_W'(det_ff[m3i_pkg::DET_W-1] ? -det_ff : det_ff);
      thr_big = m3i_pkg::MAG_W'({threshold, {SHIFT2{1'b0}}});
      sing_in = (det_ff == '0) || (dm_in < thr_big);
      for (int i = 0; i < 9; i++) begin
         cm_in[i]  = m3i_pkg::CMAG_W'(cof_s5_ff[i][m3i_pkg::COF_W-1] ? -cof_s5_ff[i]
                                                                     : cof_s5_ff[i]);
         neg_in[i] = cof_s5_ff[i][m3i_pkg::COF_W-1] ^ det_ff[m3i_pkg::DET_W-1];
      end
   end

   // divider operands: num = 2*|c|*2^32 + |d|, den = 2*|d|, with quotient range check
   always_comb begin
      den_in = {dm_ff[m3i_pkg::MAG_W-2:0], 1'b0};
      for (int i = 0; i < 9; i++) begin
         num_in[i] = m3i_pkg::MAG_W'({cm_ff[i], {(SHIFT2 + 1){1'b0}}}) + dm_ff;
         big_in[i] = m3i_pkg::MAG_W'(num_in[i][m3i_pkg::MAG_W-1:m3i_pkg::QUO_W]) >= den_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      cof_s3_ff  <= cof;
      term_ff    <= term_in;
      cof_s4_ff  <= cof_s3_ff;
      det_ff     <= det_in;
      cof_s5_ff  <= cof_s4_ff;
      dm_ff      <= dm_in;
      cm_ff      <= cm_in;
      neg_s6_ff  <= neg_in;
      sing_s6_ff <= sing_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      big_ff     <= big_in;
      neg_s7_ff  <= neg_s6_ff;
      sing_s7_ff <= sing_s6_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_ctl = '{valid: valid_ff[4], singular: sing_s7_ff};
   assign den     = den_ff;
   assign num     = num_ff;
   assign neg     = neg_s7_ff;
   assign big     = big_ff;

endmodule
`default_nettype wire

// ===== design/m3i_divider.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// m3i_divider
// One lane: pipelined restoring divider, one quotient bit per stage, then
// sign and saturation to the element range.
// -----------------------------------------------------------------------------
module m3i_divider (
   input  logic                clock,
   input  m3i_pkg::mag_type    num,
   input  m3i_pkg::mag_type    den,
   input  logic                neg,
   input  logic                big,
   output m3i_pkg::elem_type   quo,
   output logic                sat
);

   localparam int STEPS = m3i_pkg::DIV_STEPS;
   localparam int QW    = m3i_pkg::QUO_W;

   m3i_pkg::mag_type rem_src [STEPS];
   m3i_pkg::quo_type low_src [STEPS];
   m3i_pkg::quo_type q_src   [STEPS];
   m3i_pkg::mag_type den_src [STEPS];
   logic             neg_src [STEPS];
   logic             big_src [STEPS];
   m3i_pkg::mag_type trial   [STEPS];
   m3i_pkg::mag_type rem_in  [STEPS];
   m3i_pkg::quo_type q_in    [STEPS];
   m3i_pkg::mag_type rem_ff  [STEPS];
   m3i_pkg::quo_type low_ff  [STEPS];
   m3i_pkg::quo_type q_ff    [STEPS];
   m3i_pkg::mag_type den_ff  [STEPS];
   logic             neg_ff  [STEPS];
   logic             big_ff  [STEPS];

   logic [QW:0]       lim;
   logic              sat_in;
   m3i_pkg::quo_type  mag;
   logic              neg_eff;
   m3i_pkg::elem_type quo_in;
   m3i_pkg::elem_type quo_ff;
   logic              sat_ff;

   // stage inputs: first from the operands, then from the previous stage
   always_comb begin
      rem_src[0] = m3i_pkg::MAG_W'(num[m3i_pkg::MAG_W-1:QW]);
      low_src[0] = num[QW-1:0];
      q_src[0]   = '0;
      den_src[0] = den;
      neg_src[0] = neg;
      big_src[0] = big;
      for (int s = 1; s < STEPS; s++) begin
         rem_src[s] = rem_ff[s-1];
         low_src[s] = low_ff[s-1];
         q_src[s]   = q_ff[s-1];
         den_src[s] = den_ff[s-1];
         neg_src[s] = neg_ff[s-1];
         big_src[s] = big_ff[s-1];
      end
   end

   // one compare and subtract per stage
   always_comb begin
      for (int s = 0; s < STEPS; s++) begin
         trial[s] = {rem_src[s][m3i_pkg::MAG_W-2:0], low_src[s][QW-1]};
         if (trial[s] >= den_src[s]) begin
            rem_in[s] = trial[s] - den_src[s];
            q_in[s]   = {q_src[s][QW-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[s];
            q_in[s]   = {q_src[s][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STEPS; s++) begin
         rem_ff[s] <= rem_in[s];
         low_ff[s] <= {low_src[s][QW-2:0], 1'b0};
         q_ff[s]   <= q_in[s];
         den_ff[s] <= den_src[s];
         neg_ff[s] <= neg_src[s];
         big_ff[s] <= big_src[s];
      end
   end

   // sign and clip: negative results may reach one step further
   always_comb begin
      lim     = ((QW + 1)'(1) << (m3i_pkg::ELEM_W - 1)) - (QW + 1)'(!neg_ff[STEPS-1]);
      sat_in  = big_ff[STEPS-1] || ({1'b0, q_ff[STEPS-1]} > lim);
      mag     = sat_in ? lim[QW-1:0] : q_ff[STEPS-1];
      neg_eff = neg_ff[STEPS-1] && (big_ff[STEPS-1] || (q_ff[STEPS-1] != '0));
      quo_in  = neg_eff ? m3i_pkg::elem_type'(-mag) : m3i_pkg::elem_type'(mag);
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule
`default_nettype wire

// ===== design/matrix3_inverse.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a signed Q16.16 3x3 matrix as adjugate over determinant, with a
// programmable singular threshold and saturation of the result elements.
// -----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy is always low.
// Each request gives exactly one result, marked by rsp_valid for one cycle;
// requests on consecutive cycles give results on consecutive cycles. The
// latency is set mostly by the nine parallel division lanes, each forming one
// quotient bit per pipeline stage over 32 stages; the rest is two stages of
// cofactor products, five of determinant and operand setup, one clip stage and
// the output register. The receiver cannot stall.
// Write csr_wdata with csr_we high only while no request is in flight.
module matrix3_inverse (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  m3i_pkg::elem_type req_elem_r0c0,
   input  m3i_pkg::elem_type req_elem_r0c1,
   input  m3i_pkg::elem_type req_elem_r0c2,
   input  m3i_pkg::elem_type req_elem_r1c0,
   input  m3i_pkg::elem_type req_elem_r1c1,
   input  m3i_pkg::elem_type req_elem_r1c2,
   input  m3i_pkg::elem_type req_elem_r2c0,
   input  m3i_pkg::elem_type req_elem_r2c1,
   input  m3i_pkg::elem_type req_elem_r2c2,
   input  logic              csr_we,
   input  m3i_pkg::thr_type  csr_wdata,
   output logic              rsp_valid,
   output m3i_pkg::elem_type rsp_inv_r0c0,
   output m3i_pkg::elem_type rsp_inv_r0c1,
   output m3i_pkg::elem_type rsp_inv_r0c2,
   output m3i_pkg::elem_type rsp_inv_r1c0,
   output m3i_pkg::elem_type rsp_inv_r1c1,
   output m3i_pkg::elem_type rsp_inv_r1c2,
   output m3i_pkg::elem_type rsp_inv_r2c0,
   output m3i_pkg::elem_type rsp_inv_r2c1,
   output m3i_pkg::elem_type rsp_inv_r2c2,
   output logic              rsp_singular,
   output logic              rsp_saturated
);

   m3i_pkg::elem_type elem [9];
   m3i_pkg::thr_type  thr_ff;
   logic              cof_valid;
   m3i_pkg::elem_type row0 [3];
   m3i_pkg::cof_type  cof [9];
   m3i_pkg::ctl_type  det_ctl;
   m3i_pkg::mag_type  den;
   m3i_pkg::mag_type  num [9];
   logic              neg [9];
   logic              big [9];
   m3i_pkg::elem_type div_quo [9];
   logic              div_sat [9];
   m3i_pkg::ctl_type  ctl_ff [m3i_pkg::DIV_LAT];
   m3i_pkg::ctl_type  ctl_last;
   m3i_pkg::elem_type inv_in [9];
   m3i_pkg::elem_type inv_ff [9];
   logic              sat_in;
   logic              sat_ff;
   logic              sing_ff;
   logic              valid_ff;

   assign busy = 1'b0;

   assign elem = '{req_elem_r0c0, req_elem_r0c1, req_elem_r0c2,
                   req_elem_r1c0, req_elem_r1c1, req_elem_r1c2,
                   req_elem_r2c0, req_elem_r2c1, req_elem_r2c2};

   // singular threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= m3i_pkg::thr_type'(1);
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   m3i_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .elem      (elem),
      .out_valid (cof_valid),
      .row0      (row0),
      .cof       (cof)
   );

   m3i_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .row0      (row0),
      .cof       (cof),
      .threshold (thr_ff),
      .out_ctl   (det_ctl),
      .den       (den),
      .num       (num),
      .neg       (neg),
      .big       (big)
   );

   // nine division lanes
   for (genvar i = 0; i < 9; i++) begin : g_lane
      m3i_divider u_divider (
         .clock (clock),
         .num   (num[i]),
         .den   (den),
         .neg   (neg[i]),
         .big   (big[i]),
         .quo   (div_quo[i]),
         .sat   (div_sat[i])
      );
   end

   // control delay matching the division lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < m3i_pkg::DIV_LAT; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= det_ctl;
         for (int k = 1; k < m3i_pkg::DIV_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign ctl_last = ctl_ff[m3i_pkg::DIV_LAT-1];

   // identity for singular matrices, else the lane results
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (ctl_last.singular) begin
            inv_in[i] = ((i % 4) == 0) ? m3i_pkg::ELEM_ONE : '0;
         end else begin
            inv_in[i] = div_quo[i];
            sat_in    = sat_in | div_sat[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      inv_ff  <= inv_in;
      sat_ff  <= sat_in;
      sing_ff <= ctl_last.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_last.valid;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_inv_r0c0  = inv_ff[0];
   assign rsp_inv_r0c1  = inv_ff[1];
   assign rsp_inv_r0c2  = inv_ff[2];
   assign rsp_inv_r1c0  = inv_ff[3];
   assign rsp_inv_r1c1  = inv_ff[4];
   assign rsp_inv_r1c2  = inv_ff[5];
   assign rsp_inv_r2c0  = inv_ff[6];
   assign rsp_inv_r2c1  = inv_ff[7];
   assign rsp_inv_r2c2  = inv_ff[8];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;

   // every result traces back to a request a fixed latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, m3i_pkg::LATENCY))
      else $error("result without a matching request");

   // singular results carry the identity and no saturation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_inv_r0c0 == m3i_pkg::ELEM_ONE &&
         rsp_inv_r1c1 == m3i_pkg::ELEM_ONE && rsp_inv_r0c1 == '0 && !rsp_saturated))
      else $error("singular result is not the identity");

endmodule
`default_nettype wire

// ===== tb/matrix3_inverse_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// matrix3_inverse_tb
// Self-checking testbench of the 3x3 fixed-point matrix inverter. A queue of
// requests and threshold writes feeds a bursty driver. Each accepted request
// is run through an exact wide-integer inverse predictor. A monitor compares
// every result, field by field, with the oldest predicted inverse.
// -----------------------------------------------------------------------------
module matrix3_inverse_tb;

   typedef struct {
      bit                is_cfg;
      m3i_pkg::elem_type m [9];
      m3i_pkg::thr_type  thr;
   } work_type;

   typedef struct {
      m3i_pkg::elem_type inv [9];
      bit                sing;
      bit                sat;
   } inv_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   m3i_pkg::elem_type req_m [9];
   logic              csr_we = 1'b0;
   m3i_pkg::thr_type  csr_wdata = '0;
   logic              rsp_valid;
   m3i_pkg::elem_type rsp_m [9];
   logic              rsp_singular;
   logic              rsp_saturated;

   work_type          work_queue [$];
   inv_type           inverse_queue [$];
   m3i_pkg::thr_type  thr_model = m3i_pkg::thr_type'(1);
   int                mismatches = 0;
   int                burst_left = 0;
   int                gap_left = 0;
   int                quiet = 0;
   bit                driving_done = 0;
   work_type          held;

   initial for (int i = 0; i < 9; i++) req_m[i] = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   matrix3_inverse DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_elem_r0c0(req_m[0]), .req_elem_r0c1(req_m[1]), .req_elem_r0c2(req_m[2]),
      .req_elem_r1c0(req_m[3]), .req_elem_r1c1(req_m[4]), .req_elem_r1c2(req_m[5]),
      .req_elem_r2c0(req_m[6]), .req_elem_r2c1(req_m[7]), .req_elem_r2c2(req_m[8]),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_inv_r0c0(rsp_m[0]), .rsp_inv_r0c1(rsp_m[1]), .rsp_inv_r0c2(rsp_m[2]),
      .rsp_inv_r1c0(rsp_m[3]), .rsp_inv_r1c1(rsp_m[4]), .rsp_inv_r1c2(rsp_m[5]),
      .rsp_inv_r2c0(rsp_m[6]), .rsp_inv_r2c1(rsp_m[7]), .rsp_inv_r2c2(rsp_m[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated)
   );

   // exact inverse: adjugate over determinant, rounded half away from zero
   function automatic inv_type inverse_of(m3i_pkg::elem_type m [9], m3i_pkg::thr_type thr);
      logic signed [127:0] a [9];
      logic signed [127:0] c [9];
      logic signed [127:0] det;
      logic [127:0] dm, nm, num, den, q, lim, thr_wide;
      bit neg;
      inv_type r;
      r.sat = 0;
      r.sing = 0;
      for (int i = 0; i < 9; i++) a[i] = m[i];
      for (int i = 0; i < 9; i++)
         c[i] = a[m3i_pkg::COF_IDX[i][0]] * a[m3i_pkg::COF_IDX[i][1]]
              - a[m3i_pkg::COF_IDX[i][2]] * a[m3i_pkg::COF_IDX[i][3]];
      det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
      dm = (det < 0) ? -det : det;
      thr_wide = {97'b0, thr} << (2 * m3i_pkg::FRAC_BITS);
      if (det == 0 || dm < thr_wide) begin
         r.sing = 1;
         for (int i = 0; i < 9; i++) r.inv[i] = (i % 4 == 0) ? m3i_pkg::ELEM_ONE : '0;
         return r;
      end
      for (int i = 0; i < 9; i++) begin
         neg = (c[i] < 0) != (det < 0);
         nm = (c[i] < 0) ? -c[i] : c[i];
         num = (nm << (2 * m3i_pkg::FRAC_BITS + 1)) + dm;
         den = dm << 1;
         q = num / den;
         if (q == 0) neg = 0;
         lim = neg ? (128'd1 << (m3i_pkg::ELEM_W - 1))
                   : ((128'd1 << (m3i_pkg::ELEM_W - 1)) - 1);
         if (q > lim) begin
            q = lim;
            r.sat = 1;
         end
         r.inv[i] = neg ? -q[m3i_pkg::ELEM_W-1:0] : q[m3i_pkg::ELEM_W-1:0];
      end
      return r;
   endfunction

   function automatic m3i_pkg::elem_type rand_elem();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: return m3i_pkg::elem_type'(v);
         1: return m3i_pkg::elem_type'($signed(v) >>> $urandom_range(0, 31));
         default: return m3i_pkg::elem_type'($signed(v) >>> $urandom_range(12, 18));
      endcase
   endfunction

   task automatic add_matrix(input m3i_pkg::elem_type m [9]);
      work_type w;
      w.is_cfg = 0;
      w.m = m;
      w.thr = '0;
      work_queue.push_back(w);
   endtask

   task automatic add_thr(input m3i_pkg::thr_type t);
      work_type w;
      w.is_cfg = 1;
      w.thr = t;
      for (int i = 0; i < 9; i++) w.m[i] = '0;
      work_queue.push_back(w);
   endtask

   // matrix of random perturbations on a diagonal of +2.0 or -2.0 entries
   task automatic add_good_matrix();
      m3i_pkg::elem_type m [9];
      for (int i = 0; i < 9; i++) begin
         m[i] = m3i_pkg::elem_type'($signed($urandom) >>> $urandom_range(14, 20));
         if (i % 4 == 0)
            m[i] = m[i] + ($urandom_range(0, 1) ? m3i_pkg::ELEM_ONE <<< 1
                                                : -(m3i_pkg::ELEM_ONE <<< 1));
      end
      add_matrix(m);
   endtask

   task automatic add_noise_matrix();
      m3i_pkg::elem_type m [9];
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      add_matrix(m);
   endtask

   // stimulus plan
   initial begin
      m3i_pkg::elem_type m [9];
      // identity at default threshold
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? m3i_pkg::ELEM_ONE : '0;
      add_matrix(m);
      // zero matrix is singular at any threshold
      for (int i = 0; i < 9; i++) m[i] = '0;
      add_matrix(m);
      // all extremes
      for (int i = 0; i < 9; i++) m[i] = 32'h7fffffff;
      add_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = 32'h80000000;
      add_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'h80000000 : '0;
      add_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'h7fffffff : '0;
      add_matrix(m);
      // tiny diagonal, then with one negative entry: singular at the default threshold
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'sd256 : '0;
      add_matrix(m);
      m[4] = -32'sd256;
      add_matrix(m);
      // diagonal 2.0 and -4.0: exact; diagonal 3.0, then with -3.0: rounded
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? m3i_pkg::ELEM_ONE <<< 1 : '0;
      m[8] = -(m3i_pkg::ELEM_ONE <<< 2);
      add_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 3 * m3i_pkg::ELEM_ONE : '0;
      add_matrix(m);
      m[0] = -3 * m3i_pkg::ELEM_ONE;
      add_matrix(m);
      // off-diagonal permutation
      for (int i = 0; i < 9; i++)
         m[i] = (i == 1 || i == 5 || i == 6) ? m3i_pkg::ELEM_ONE : '0;
      add_matrix(m);
      for (int i = 0; i < 6; i++) add_noise_matrix();
      // threshold zero: only exact zero determinant is singular
      add_thr('0);
      for (int i = 0; i < 9; i++) m[i] = '0;
      add_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'sd1 : '0;
      add_matrix(m);
      for (int i = 0; i < 200; i++) if ($urandom_range(0, 3)) add_good_matrix();
      else add_noise_matrix();
      // largest threshold: nearly everything singular
      add_thr(m3i_pkg::thr_type'(31'h7fffffff));
      for (int i = 0; i < 9; i++) m[i] = 32'h7fffffff;
      add_matrix(m);
      for (int i = 0; i < 150; i++) if ($urandom_range(0, 1)) add_good_matrix();
      else add_noise_matrix();
      // a spread of other thresholds
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: add_thr(m3i_pkg::thr_type'(m3i_pkg::ELEM_ONE));
            1: add_thr(m3i_pkg::thr_type'($urandom_range(0, 255)));
            2: add_thr(m3i_pkg::thr_type'(1));
            default: add_thr(m3i_pkg::thr_type'($urandom >> $urandom_range(1, 31)));
         endcase
         for (int i = 0; i < 155; i++) if ($urandom_range(0, 3)) add_good_matrix();
         else add_noise_matrix();
      end
   end

   // driver: bursts with random gaps, threshold writes only when idle
   always @(posedge clock) begin
      bit we_next;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         we_next = 1'b0;
         if (start && !busy) inverse_queue.push_back(inverse_of(held.m, thr_model));
         if (csr_we) thr_model = csr_wdata;
         if (inverse_queue.size() == 0 && !(start && !busy)) quiet = quiet + 1;
         else quiet = 0;
         if (start && busy) begin
            // hold the current request
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (work_queue.size() == 0) begin
            start <= 1'b0;
            driving_done = 1;
         end else if (work_queue[0].is_cfg) begin
            start <= 1'b0;
            if (quiet > m3i_pkg::LATENCY + 2 && !csr_we) begin
               we_next = 1'b1;
               csr_wdata <= work_queue[0].thr;
               void'(work_queue.pop_front());
               quiet = 0;
            end
         end else begin
            held = work_queue.pop_front();
            for (int i = 0; i < 9; i++) req_m[i] <= held.m[i];
            start <= 1'b1;
            if (burst_left > 0) burst_left = burst_left - 1;
            else begin
               burst_left = $urandom_range(0, 40);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 3);
                  2: gap_left = $urandom_range(1, 12);
                  default: gap_left = $urandom_range(20, 60);
               endcase
            end
         end
         csr_we <= we_next;
      end
   end

   // monitor: compare each result with the oldest predicted inverse
   always @(posedge clock) begin
      inv_type want;
      bit bad;
      if (!reset && rsp_valid) begin
         if (inverse_queue.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result with no request pending");
         end else begin
            want = inverse_queue.pop_front();
            bad = (rsp_singular !== want.sing) || (rsp_saturated !== want.sat);
            for (int i = 0; i < 9; i++) if (rsp_m[i] !== want.inv[i]) bad = 1;
            if (bad) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("mismatch: singular exp %0d got %0d, saturated exp %0d got %0d",
                           want.sing, rsp_singular, want.sat, rsp_saturated);
                  for (int i = 0; i < 9; i++)
                     $display("  inv[%0d] exp %h got %h", i, want.inv[i], rsp_m[i]);
               end
            end
         end
      end
   end

   // reset, then wait for drain
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (driving_done && inverse_queue.size() == 0);
      repeat (m3i_pkg::LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && inverse_queue.size() == 0)
         $display("matrix3_inverse regression: pass");
      else
         $display("matrix3_inverse regression: fail");
      $finish;
   end

   initial begin
      #10ms;
      $display("matrix3_inverse regression: fail");
      $finish;
   end

endmodule
